// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the checker module of this project.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge, skip while reset is asserted.
`define GSP_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("gsp assertion failed");

// Check that a condition in one cycle implies another in the next cycle.
`define GSP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("gsp assertion failed");

`endif

// ===== rtl/gsp_pkg.sv =====
// Shared types and constants of the shortest path block.
// No dependencies; imported by the top level, the sequencer and the checker.
package gsp_pkg;

	localparam int NODES_DEF       = 16;
	localparam int WEIGHT_BITS_DEF = 16;
	localparam int LEN_BITS        = 20;

	localparam logic [LEN_BITS-1:0] LEN_MAX = '1;

	localparam logic [1:0] OP_SET_EDGE      = 2'd0;
	localparam logic [1:0] OP_REMOVE_EDGE   = 2'd1;
	localparam logic [1:0] OP_REMOVE_VERTEX = 2'd2;
	localparam logic [1:0] OP_QUERY         = 2'd3;

	typedef struct packed {
		logic [1:0]  operation;
		logic [3:0]  source_vertex;
		logic [3:0]  dest_vertex;
		logic [15:0] edge_weight;
	} in_item_t;

	typedef struct packed {
		logic                path_found;
		logic [LEN_BITS-1:0] path_length;
	} out_item_t;

endpackage

// ===== rtl/weighted_graph_shortest_path_top.sv =====
// Top level of the weighted graph shortest path block.
// Depends on gsp_pkg, gsp_ram and gsp_ctrl.
//
// item channel: one beat per operation (set edge, remove edge, remove vertex,
// shortest path query), taken when item_valid is high and item_stall is low.
// result channel: one beat per operation with path_found and path_length
// (both zero for edits and failed queries).
// Work per operation: set / remove edge write the edge memory at accept; remove
// vertex clears the row and the column of the vertex one edge at a time; a query
// skips unreached rows and sweeps each reached row (one edge relaxed per
// cycle through the edge memory read port) for up to NODES rounds, stopping
// early after a round that changes nothing, then reads the result out of the
// distance memory (the final step is skipped on a miss).
// Throughput: one operation in work at a time; item_stall rises once a beat is
// taken and stays high until its result has moved to the output register.
// Reset: a clearing pass wipes every edge; item_stall
// stays high until it ends.
// Receiver stall: hold the result in the output register; the next item is
// still taken, and its result waits in the sequencer until the register frees.
module weighted_graph_shortest_path_top #(
	parameter int NODES       = gsp_pkg::NODES_DEF,
	parameter int WEIGHT_BITS = gsp_pkg::WEIGHT_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	output logic               item_stall,
	input  gsp_pkg::in_item_t  item,
	output logic               result_valid,
	input  logic               result_stall,
	output gsp_pkg::out_item_t result
);
	import gsp_pkg::*;

	localparam int VIDX = $clog2(NODES);
	localparam int EA   = $clog2(NODES * NODES);
	// wide enough for the length of any simple path, plus a spare bit
	localparam int DB   = WEIGHT_BITS + $clog2(NODES) + 1;

	logic             res_valid, res_ready;
	out_item_t        res;
	logic             e_wr_en, e_rd_en, d_wr_en, d_rd_en;
	logic [EA-1:0]    e_wr_addr, e_rd_addr;
	logic [WEIGHT_BITS:0] e_wr_data, e_rd_data;
	logic [VIDX-1:0]  d_wr_addr, d_rd_addr;
	logic [DB-1:0]    d_wr_data, d_rd_data;

	logic      result_valid_q;
	out_item_t result_q;

	gsp_ctrl #(
		.NODES       (NODES),
		.WEIGHT_BITS (WEIGHT_BITS),
		.VIDX        (VIDX),
		.EA          (EA),
		.DB          (DB)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item       (item),
		.item_stall (item_stall),
		.res_valid  (res_valid),
		.res        (res),
		.res_ready  (res_ready),
		.e_wr_en    (e_wr_en),
		.e_wr_addr  (e_wr_addr),
		.e_wr_data  (e_wr_data),
		.e_rd_en    (e_rd_en),
		.e_rd_addr  (e_rd_addr),
		.e_rd_data  (e_rd_data),
		.d_wr_en    (d_wr_en),
		.d_wr_addr  (d_wr_addr),
		.d_wr_data  (d_wr_data),
		.d_rd_en    (d_rd_en),
		.d_rd_addr  (d_rd_addr),
		.d_rd_data  (d_rd_data)
	);

	// adjacency matrix: present bit above the weight, one word per edge
	gsp_ram #(
		.WIDTH (WEIGHT_BITS + 1),
		.DEPTH (NODES * NODES)
	) u_edge_ram (
		.clk     (clk),
		.wr_en   (e_wr_en),
		.wr_addr (e_wr_addr),
		.wr_data (e_wr_data),
		.rd_en   (e_rd_en),
		.rd_addr (e_rd_addr),
		.rd_data (e_rd_data)
	);

	// tentative distance per vertex; the reached flags live in the sequencer
	gsp_ram #(
		.WIDTH (DB),
		.DEPTH (NODES)
	) u_dist_ram (
		.clk     (clk),
		.wr_en   (d_wr_en),
		.wr_addr (d_wr_addr),
		.wr_data (d_wr_data),
		.rd_en   (d_rd_en),
		.rd_addr (d_rd_addr),
		.rd_data (d_rd_data)
	);

	// output register: load when empty or being drained this cycle
	assign res_ready = !result_valid_q || !result_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (res_valid && res_ready) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	// hold the beat while stalled
	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			result_q <= res;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule

// ===== rtl/gsp_ram.sv =====
// Generic simple dual port RAM: one write port, one registered read port.
// No dependencies.
module gsp_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

// ===== rtl/gsp_ctrl.sv =====
// Sequencer of the shortest path block: clearing pass, edge edits and
// Bellman-Ford relaxation over the edge and distance memories. Uses gsp_pkg.
module gsp_ctrl #(
	parameter int NODES       = gsp_pkg::NODES_DEF,
	parameter int WEIGHT_BITS = gsp_pkg::WEIGHT_BITS_DEF,
	parameter int VIDX        = $clog2(NODES),
	parameter int EA          = $clog2(NODES * NODES),
	parameter int DB          = WEIGHT_BITS + $clog2(NODES) + 1
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   item_valid,
	input  gsp_pkg::in_item_t      item,
	output logic                   item_stall,
	output logic                   res_valid,
	output gsp_pkg::out_item_t     res,
	input  logic                   res_ready,
	output logic                   e_wr_en,
	output logic [EA-1:0]          e_wr_addr,
	output logic [WEIGHT_BITS:0]   e_wr_data,
	output logic                   e_rd_en,
	output logic [EA-1:0]          e_rd_addr,
	input  logic [WEIGHT_BITS:0]   e_rd_data,
	output logic                   d_wr_en,
	output logic [VIDX-1:0]        d_wr_addr,
	output logic [DB-1:0]          d_wr_data,
	output logic                   d_rd_en,
	output logic [VIDX-1:0]        d_rd_addr,
	input  logic [DB-1:0]          d_rd_data
);
	import gsp_pkg::*;

	localparam int CW = (DB > LEN_BITS) ? DB : LEN_BITS;
	localparam logic [EA-1:0]   CLR_LAST = EA'(NODES * NODES - 1);
	localparam logic [VIDX-1:0] IDX_LAST = VIDX'(NODES - 1);

	localparam logic [3:0] S_CLEAR  = 4'd0;
	localparam logic [3:0] S_IDLE   = 4'd1;
	localparam logic [3:0] S_VTX    = 4'd2;
	localparam logic [3:0] S_ROW    = 4'd3;
	localparam logic [3:0] S_ROWRD  = 4'd4;
	localparam logic [3:0] S_SWEEP  = 4'd5;
	localparam logic [3:0] S_ROWEND = 4'd6;
	localparam logic [3:0] S_FINRD  = 4'd7;
	localparam logic [3:0] S_FIN    = 4'd8;
	localparam logic [3:0] S_DONE   = 4'd9;

	logic [3:0]          state_q;
	logic [EA-1:0]       clr_q;
	logic [VIDX-1:0]     src_q, dst_q, i_q, j_q, k_q, round_q;
	logic                phase_q, changed_q;
	logic [NODES-1:0]    known_q;
	logic [DB-1:0]       di_q;
	logic                res_found_q;
	logic [LEN_BITS-1:0] res_len_q;

	logic            accept, src_ok, dst_ok, improve;
	logic [VIDX-1:0] src_in, dst_in;
	logic [DB-1:0]   cand;
	logic [CW-1:0]   d_ext;
	logic [3:0]      adv_state;
	logic [VIDX-1:0] adv_i, adv_round;
	logic            adv_changed;

	function automatic logic [EA-1:0] eaddr(input logic [VIDX-1:0] r,
			input logic [VIDX-1:0] c);
		eaddr = EA'(r) * EA'(NODES) + EA'(c);
	endfunction

	assign accept = item_valid && (state_q == S_IDLE);
	assign src_in = VIDX'(item.source_vertex);
	assign dst_in = VIDX'(item.dest_vertex);
	assign src_ok = 32'(item.source_vertex) < 32'(NODES);
	assign dst_ok = 32'(item.dest_vertex) < 32'(NODES);

	// relax edge (i, j): data of the read issued last cycle is present now
	assign cand    = di_q + DB'(e_rd_data[WEIGHT_BITS-1:0]);
	assign improve = (state_q == S_SWEEP) && e_rd_data[WEIGHT_BITS] &&
		(!known_q[j_q] || (cand < d_rd_data));
	assign d_ext   = CW'(d_rd_data);

	// advance to the next row, the next round or the final read
	always_comb begin
		adv_state   = S_ROW;
		adv_i       = i_q + VIDX'(1);
		adv_round   = round_q;
		adv_changed = changed_q;
		if (i_q == IDX_LAST) begin
			adv_i = '0;
			if (changed_q && (round_q != IDX_LAST)) begin
				adv_round   = round_q + VIDX'(1);
				adv_changed = 1'b0;
			end else begin
				adv_state = S_FINRD;
			end
		end
	end

	always_comb begin
		e_wr_en   = 1'b0;
		e_wr_addr = '0;
		e_wr_data = '0;
		e_rd_en   = 1'b0;
		e_rd_addr = '0;
		d_wr_en   = 1'b0;
		d_wr_addr = '0;
		d_wr_data = '0;
		d_rd_en   = 1'b0;
		d_rd_addr = '0;
		case (state_q)
			S_CLEAR: begin
				e_wr_en   = 1'b1;
				e_wr_addr = clr_q;
			end
			S_IDLE: begin
				if (accept && src_ok && dst_ok) begin
					case (item.operation)
						OP_SET_EDGE: begin
							e_wr_en   = 1'b1;
							e_wr_addr = eaddr(src_in, dst_in);
							e_wr_data = {1'b1, WEIGHT_BITS'(item.edge_weight)};
						end
						OP_REMOVE_EDGE: begin
							e_wr_en   = 1'b1;
							e_wr_addr = eaddr(src_in, dst_in);
						end
						OP_QUERY: begin
							d_wr_en   = 1'b1;
							d_wr_addr = src_in;
						end
						default: ;
					endcase
				end
			end
			S_VTX: begin
				e_wr_en   = 1'b1;
				e_wr_addr = phase_q ? eaddr(k_q, src_q) : eaddr(src_q, k_q);
			end
			S_ROW: begin
				d_rd_en   = 1'b1;
				d_rd_addr = i_q;
			end
			S_ROWRD: begin
				e_rd_en   = 1'b1;
				e_rd_addr = eaddr(i_q, VIDX'(0));
				d_rd_en   = 1'b1;
			end
			S_SWEEP: begin
				if (j_q != IDX_LAST) begin
					e_rd_en   = 1'b1;
					e_rd_addr = eaddr(i_q, j_q + VIDX'(1));
					d_rd_en   = 1'b1;
					d_rd_addr = j_q + VIDX'(1);
				end
				if (improve) begin
					d_wr_en   = 1'b1;
					d_wr_addr = j_q;
					d_wr_data = cand;
				end
			end
			S_FINRD: begin
				d_rd_en   = 1'b1;
				d_rd_addr = dst_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_CLEAR;
			clr_q     <= '0;
			known_q   <= '0;
			changed_q <= 1'b0;
			i_q       <= '0;
			j_q       <= '0;
			k_q       <= '0;
			round_q   <= '0;
			phase_q   <= 1'b0;
		end else begin
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + EA'(1);
					if (clr_q == CLR_LAST) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						i_q       <= '0;
						k_q       <= '0;
						round_q   <= '0;
						phase_q   <= 1'b0;
						changed_q <= 1'b0;
						case (item.operation)
							OP_REMOVE_VERTEX: begin
								state_q <= src_ok ? S_VTX : S_DONE;
							end
							OP_QUERY: begin
								if (src_ok && dst_ok) begin
									known_q <= {{(NODES-1){1'b0}}, 1'b1} << src_in;
									state_q <= S_ROW;
								end else begin
									state_q <= S_DONE;
								end
							end
							default: begin
								state_q <= S_DONE;
							end
						endcase
					end
				end
				S_VTX: begin
					phase_q <= !phase_q;
					if (phase_q) begin
						if (k_q == IDX_LAST) begin
							state_q <= S_DONE;
						end else begin
							k_q <= k_q + VIDX'(1);
						end
					end
				end
				S_ROW: begin
					if (known_q[i_q]) begin
						state_q <= S_ROWRD;
					end else begin
						state_q   <= adv_state;
						i_q       <= adv_i;
						round_q   <= adv_round;
						changed_q <= adv_changed;
					end
				end
				S_ROWRD: begin
					j_q     <= '0;
					state_q <= S_SWEEP;
				end
				S_SWEEP: begin
					if (improve) begin
						known_q[j_q] <= 1'b1;
						changed_q    <= 1'b1;
					end
					if (j_q == IDX_LAST) begin
						state_q <= S_ROWEND;
					end else begin
						j_q <= j_q + VIDX'(1);
					end
				end
				S_ROWEND: begin
					state_q   <= adv_state;
					i_q       <= adv_i;
					round_q   <= adv_round;
					changed_q <= adv_changed;
				end
				S_FINRD: begin
					state_q <= known_q[dst_q] ? S_FIN : S_DONE;
				end
				S_FIN: begin
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (res_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			src_q       <= src_in;
			dst_q       <= dst_in;
			res_found_q <= 1'b0;
			res_len_q   <= '0;
		end
		if (state_q == S_ROWRD) begin
			di_q <= d_rd_data;
		end
		if (state_q == S_FIN) begin
			res_found_q <= 1'b1;
			res_len_q   <= (d_ext > CW'(LEN_MAX)) ? LEN_MAX : LEN_BITS'(d_ext);
		end
	end

	assign item_stall      = (state_q != S_IDLE);
	assign res_valid       = (state_q == S_DONE);
	assign res.path_found  = res_found_q;
	assign res.path_length = res_len_q;

endmodule

// ===== rtl/gsp_checker.sv =====
// Port-level checker of the shortest path block, bound to the top level.
// Depends on gsp_pkg and assert_macros.svh.
`include "assert_macros.svh"

module gsp_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               item_valid,
	input logic               item_stall,
	input gsp_pkg::in_item_t  item,
	input logic               result_valid,
	input logic               result_stall,
	input gsp_pkg::out_item_t result
);
	import gsp_pkg::*;

	// a stalled result beat stays and does not change
	`GSP_ASSERT_NEXT(a_result_hold, clk, arst_n, result_valid && result_stall, result_valid && $stable(result))

	// a miss never carries a length
	`GSP_ASSERT(a_miss_zero, clk, arst_n, !result_valid || result.path_found || (result.path_length == '0))

	// one operation at a time: stall rises right after an accepted beat
	`GSP_ASSERT_NEXT(a_one_in_work, clk, arst_n, item_valid && !item_stall, item_stall)

endmodule

bind weighted_graph_shortest_path_top gsp_checker u_gsp_checker (.*);
